FILE: hdl/dds_pkg.sv
// Shared types and constants for the differential drive speed ramp.
// Command codes, register indexes, stream widths and the config struct.
// No dependencies.
package dds_pkg;

	localparam int SPEED_W     = 12;
	localparam int CMD_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_STOP        = 3'd0,
		CMD_FORWARD     = 3'd1,
		CMD_REVERSE     = 3'd2,
		CMD_TURN_RIGHT  = 3'd3,
		CMD_TURN_LEFT   = 3'd4,
		CMD_PIVOT_RIGHT = 3'd5,
		CMD_PIVOT_LEFT  = 3'd6,
		CMD_RAMP        = 3'd7
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_FWD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_FWD   = 3'd4;

	localparam logic [SPEED_W-1:0] FLOOR_SPEED_RST = 12'd0;
	localparam logic [SPEED_W-1:0] RISE_STEP_RST   = 12'd64;
	localparam logic [SPEED_W-1:0] FALL_STEP_RST   = 12'd128;

	typedef struct packed {
		logic [SPEED_W-1:0] floor_speed;
		logic [SPEED_W-1:0] rise_step;
		logic [SPEED_W-1:0] fall_step;
		logic               left_fwd;
		logic               right_fwd;
	} drive_cfg_t;

endpackage

FILE: hdl/dds_ramp.sv
// Speed saturation and slew-limited ramp step toward a target.
// Combinational; uses dds_pkg for the config struct and widths.
module dds_ramp import dds_pkg::*; #(
	parameter int DUTY_BITS = 12
) (
	input  drive_cfg_t         cfg,
	input  logic [SPEED_W-1:0] last_speed,
	input  logic [SPEED_W-1:0] speed,
	output logic [SPEED_W-1:0] speed_sat,
	output logic [SPEED_W-1:0] ramp_speed
);

	localparam longint DutyMax = (64'd1 << DUTY_BITS) - 64'd1;
	localparam logic [SPEED_W-1:0] SatVal =
		(DutyMax > 64'd4095) ? {SPEED_W{1'b1}} : SPEED_W'(DutyMax);

	function automatic logic [SPEED_W-1:0] sat(input logic [SPEED_W-1:0] v);
		return (v > SatVal) ? SatVal : v;
	endfunction

	logic [SPEED_W-1:0] floor_v;
	logic [SPEED_W-1:0] target;
	logic [SPEED_W-1:0] lifted;
	logic [SPEED_W:0]   sum;
	logic [SPEED_W-1:0] up_v;
	logic [SPEED_W-1:0] diff;
	logic [SPEED_W-1:0] down_v;
	logic [SPEED_W-1:0] next_v;

	always_comb begin
		speed_sat = sat(speed);
		floor_v   = sat(cfg.floor_speed);
		// raise a small nonzero target to the floor
		target = (speed_sat != '0 && speed_sat < floor_v) ? floor_v : speed_sat;
		lifted = (last_speed < floor_v) ? floor_v : last_speed;
		sum    = {1'b0, lifted} + {1'b0, cfg.rise_step};
		up_v   = (sum > {1'b0, target}) ? target : sum[SPEED_W-1:0];
		diff   = last_speed - cfg.fall_step;
		down_v = (last_speed >= cfg.fall_step && diff > target) ? diff : target;
		if (last_speed < target) begin
			next_v = up_v;
		end else if (last_speed > target) begin
			next_v = down_v;
		end else begin
			next_v = last_speed;
		end
		ramp_speed = sat(next_v);
	end

endmodule

FILE: hdl/differential_drive_speed_ramp.sv
// Differential drive speed ramp: one command in, one drive result out.
// An accepted input is held in an input register, then the result in a result register.
// Throughput: one item per cycle; a stalled result blocks the input once the input register is full.
// Reset: speed 0, both direction pins low, floor speed 0, rise step 64,
// fall step 128, both forward levels 1. Depends on dds_pkg and dds_ramp.
module differential_drive_speed_ramp import dds_pkg::*; #(
	parameter int DUTY_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] speed, [15:12] zero
	input  logic [CMD_W-1:0]       s_tuser,   // [2:0] cmd
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] left_dir_level, [1] right_dir_level, [13:2] left_duty,
	// [25:14] right_duty, [37:26] current_speed, [39:38] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SPEED_W-1:0]     cfg_data
);

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [SPEED_W-1:0] speed_s1;

	logic               m_valid_q;
	logic [SPEED_W-1:0] last_speed_q;
	logic               left_dir_q;
	logic               right_dir_q;
	drive_cfg_t         cfg_q;

	logic               left_dir_q2;
	logic               right_dir_q2;
	logic [SPEED_W-1:0] left_duty_q;
	logic [SPEED_W-1:0] right_duty_q;
	logic [SPEED_W-1:0] cur_speed_q;

	logic               advance;
	logic [SPEED_W-1:0] speed_sat;
	logic [SPEED_W-1:0] ramp_speed;
	logic               nx_left_dir;
	logic               nx_right_dir;
	logic [SPEED_W-1:0] nx_left_duty;
	logic [SPEED_W-1:0] nx_right_duty;
	logic [SPEED_W-1:0] nx_speed;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || !m_valid_q || m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {2'b00, cur_speed_q, right_duty_q, left_duty_q,
		right_dir_q2, left_dir_q2};

	dds_ramp #(.DUTY_BITS(DUTY_BITS)) u_ramp (
		.cfg        (cfg_q),
		.last_speed (last_speed_q),
		.speed      (speed_s1),
		.speed_sat  (speed_sat),
		.ramp_speed (ramp_speed)
	);

	always_comb begin
		nx_left_dir   = cfg_q.left_fwd;
		nx_right_dir  = cfg_q.right_fwd;
		nx_left_duty  = speed_sat;
		nx_right_duty = speed_sat;
		nx_speed      = speed_sat;
		case (cmd_s1)
			CMD_STOP: begin
				// hold the direction pins
				nx_left_dir   = left_dir_q;
				nx_right_dir  = right_dir_q;
				nx_left_duty  = '0;
				nx_right_duty = '0;
				nx_speed      = '0;
			end
			CMD_FORWARD: begin
			end
			CMD_REVERSE: begin
				nx_left_dir  = !cfg_q.left_fwd;
				nx_right_dir = !cfg_q.right_fwd;
			end
			CMD_TURN_RIGHT: begin
				nx_right_duty = '0;
			end
			CMD_TURN_LEFT: begin
				nx_left_duty = '0;
			end
			CMD_PIVOT_RIGHT: begin
				nx_right_dir = !cfg_q.right_fwd;
			end
			CMD_PIVOT_LEFT: begin
				nx_left_dir = !cfg_q.left_fwd;
			end
			CMD_RAMP: begin
				nx_left_duty  = ramp_speed;
				nx_right_duty = ramp_speed;
				nx_speed      = ramp_speed;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			m_valid_q    <= 1'b0;
			last_speed_q <= '0;
			left_dir_q   <= 1'b0;
			right_dir_q  <= 1'b0;
			cfg_q        <= '{floor_speed: FLOOR_SPEED_RST, rise_step: RISE_STEP_RST,
				fall_step: FALL_STEP_RST, left_fwd: 1'b1, right_fwd: 1'b1};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_valid_q    <= 1'b1;
				last_speed_q <= nx_speed;
				left_dir_q   <= nx_left_dir;
				right_dir_q  <= nx_right_dir;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_FLOOR_SPEED: cfg_q.floor_speed <= cfg_data;
					REG_RISE_STEP:   cfg_q.rise_step   <= cfg_data;
					REG_FALL_STEP:   cfg_q.fall_step   <= cfg_data;
					REG_LEFT_FWD:    cfg_q.left_fwd    <= cfg_data[0];
					REG_RIGHT_FWD:   cfg_q.right_fwd   <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= cmd_t'(s_tuser);
			speed_s1 <= s_tdata[SPEED_W-1:0];
		end
		if (advance) begin
			left_dir_q2  <= nx_left_dir;
			right_dir_q2 <= nx_right_dir;
			left_duty_q  <= nx_left_duty;
			right_duty_q <= nx_right_duty;
			cur_speed_q  <= nx_speed;
		end
	end

endmodule

FILE: hdl/dds_checker.sv
// Port-level checks for differential_drive_speed_ramp, attached by bind.
// Uses dds_pkg for widths.
module dds_checker import dds_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	logic [SPEED_W-1:0] l_duty;
	logic [SPEED_W-1:0] r_duty;
	logic [SPEED_W-1:0] c_speed;

	assign l_duty  = m_tdata[13:2];
	assign r_duty  = m_tdata[25:14];
	assign c_speed = m_tdata[37:26];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_duty_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (l_duty == c_speed || l_duty == '0) &&
			(r_duty == c_speed || r_duty == '0))
		else $error("duty differs from current speed");

	a_idle_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && l_duty == '0 && r_duty == '0 |-> c_speed == '0)
		else $error("both sides idle with nonzero speed");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind differential_drive_speed_ramp dds_checker u_dds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

FILE: verif/differential_drive_speed_ramp_tb.sv
// Self-checking bench for the differential drive speed ramp: drives command items
// and register writes with random idling, and checks every result against a predictor.
// Depends on dds_pkg and the differential_drive_speed_ramp RTL.
module differential_drive_speed_ramp_tb;
	import dds_pkg::*;

	localparam int unsigned DUTY_MAX    = (1 << SPEED_W) - 1;
	localparam int          STALL_LIMIT = 2000;
	localparam int          PHASES      = 8;
	localparam int          PHASE_ITEMS = 238;

	typedef struct packed {
		logic [1:0]         pad;
		logic [SPEED_W-1:0] speed;
		logic [SPEED_W-1:0] right_duty;
		logic [SPEED_W-1:0] left_duty;
		logic               right_dir;
		logic               left_dir;
	} drive_result_t;

	class drive_scoreboard;
		logic [SPEED_W-1:0] floor_speed, rise_step, fall_step;
		logic               left_fwd, right_fwd;
		logic [SPEED_W-1:0] speed_reg;
		logic               left_dir, right_dir;
		drive_result_t      expected_q[$];
		int                 errors;

		function new();
			floor_speed = FLOOR_SPEED_RST;
			rise_step   = RISE_STEP_RST;
			fall_step   = FALL_STEP_RST;
			left_fwd    = 1'b1;
			right_fwd   = 1'b1;
			speed_reg   = '0;
			left_dir    = 1'b0;
			right_dir   = 1'b0;
			errors      = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPEED_W-1:0] val);
			case (idx)
				REG_FLOOR_SPEED: floor_speed = val;
				REG_RISE_STEP:   rise_step   = val;
				REG_FALL_STEP:   fall_step   = val;
				REG_LEFT_FWD:    left_fwd    = val[0];
				REG_RIGHT_FWD:   right_fwd   = val[0];
				default: ;
			endcase
		endfunction

		// One slew-limited step from the stored speed toward the target.
		function logic [SPEED_W-1:0] ramp_toward(logic [SPEED_W-1:0] target);
			int unsigned cur, tgt, flr, nxt;
			cur = speed_reg;
			tgt = target;
			flr = floor_speed;
			if (tgt > 0 && tgt < flr)
				tgt = flr;
			if (cur < tgt) begin
				if (cur < flr)
					cur = flr;
				nxt = cur + rise_step;
				cur = (nxt > tgt) ? tgt : nxt;
			end else if (cur > tgt) begin
				if (cur >= fall_step && cur - fall_step > tgt)
					cur = cur - fall_step;
				else
					cur = tgt;
			end
			if (cur > DUTY_MAX)
				cur = DUTY_MAX;
			return cur[SPEED_W-1:0];
		endfunction

		function void note_input(cmd_t c, logic [SPEED_W-1:0] spd);
			drive_result_t r;
			r = '0;
			case (c)
				CMD_STOP: speed_reg = '0;
				CMD_FORWARD, CMD_TURN_RIGHT, CMD_TURN_LEFT, CMD_RAMP: begin
					left_dir  = left_fwd;
					right_dir = right_fwd;
				end
				CMD_REVERSE: begin
					left_dir  = ~left_fwd;
					right_dir = ~right_fwd;
				end
				CMD_PIVOT_RIGHT: begin
					left_dir  = left_fwd;
					right_dir = ~right_fwd;
				end
				CMD_PIVOT_LEFT: begin
					left_dir  = ~left_fwd;
					right_dir = right_fwd;
				end
				default: ;
			endcase
			if (c == CMD_RAMP)
				speed_reg = ramp_toward(spd);
			else if (c != CMD_STOP)
				speed_reg = spd;
			// the idle side of a turn carries zero duty
			if (c != CMD_STOP && c != CMD_TURN_LEFT)
				r.left_duty = speed_reg;
			if (c != CMD_STOP && c != CMD_TURN_RIGHT)
				r.right_duty = speed_reg;
			r.left_dir  = left_dir;
			r.right_dir = right_dir;
			r.speed     = speed_reg;
			expected_q.push_back(r);
		endfunction

		function void compare(string field, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, exp_v, act_v);
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] tdata);
			drive_result_t act, exp_r;
			act = drive_result_t'(tdata);
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h",
					$time, tdata);
			end else begin
				exp_r = expected_q.pop_front();
				compare("left_dir_level", exp_r.left_dir, act.left_dir);
				compare("right_dir_level", exp_r.right_dir, act.right_dir);
				compare("left_duty", exp_r.left_duty, act.left_duty);
				compare("right_duty", exp_r.right_duty, act.right_duty);
				compare("current_speed", exp_r.speed, act.speed);
				compare("pad bits", exp_r.pad, act.pad);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [11:0] speed, [15:12] zero
	logic [CMD_W-1:0]       s_tuser;   // [2:0] cmd
	logic                   m_tvalid;
	logic                   m_tready;
	// [0] left_dir_level, [1] right_dir_level, [13:2] left_duty,
	// [25:14] right_duty, [37:26] current_speed, [39:38] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [SPEED_W-1:0]     cfg_data;

	drive_scoreboard sb = new();
	bit              no_idle = 1'b0;
	int              stall_cycles = 0;

	differential_drive_speed_ramp dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 14);
	end

	// Registers first, then inputs, then results: all see pre-edge values.
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
		if (s_tvalid && s_tready)
			sb.note_input(cmd_t'(s_tuser), s_tdata[SPEED_W-1:0]);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_item(input cmd_t c, input logic [SPEED_W-1:0] spd);
		while (!no_idle && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {{(IN_TDATA_W-SPEED_W){1'b0}}, spd};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	function automatic logic [SPEED_W-1:0] pick_step();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return SPEED_W'(DUTY_MAX);
			2: return SPEED_W'($urandom_range(1, 16));
			3: return SPEED_W'($urandom_range(0, 255));
			default: return SPEED_W'($urandom_range(0, DUTY_MAX));
		endcase
	endfunction

	function automatic logic [SPEED_W-1:0] pick_speed();
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = DUTY_MAX;
			2: v = $urandom_range(1, 15);
			3: begin
				// hover around the ramp floor
				v = int'(sb.floor_speed) + $urandom_range(0, 6) - 3;
				if (v < 0) v = 0;
				if (v > DUTY_MAX) v = DUTY_MAX;
			end
			default: v = $urandom_range(0, DUTY_MAX);
		endcase
		return v[SPEED_W-1:0];
	endfunction

	initial begin
		int                 sent, run;
		logic [SPEED_W-1:0] target;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_STOP;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FLOOR_SPEED;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every command, field extremes, ramp accelerate/cap/brake/snap
		send_item(CMD_STOP, 12'd0);
		send_item(CMD_FORWARD, 12'd4095);
		send_item(CMD_STOP, 12'd1234);
		send_item(CMD_REVERSE, 12'd0);
		send_item(CMD_REVERSE, 12'd4095);
		send_item(CMD_TURN_RIGHT, 12'd2048);
		send_item(CMD_TURN_LEFT, 12'd1);
		send_item(CMD_PIVOT_RIGHT, 12'd4095);
		send_item(CMD_PIVOT_LEFT, 12'd2730);
		send_item(CMD_STOP, 12'd0);
		send_item(CMD_RAMP, 12'd1000);
		send_item(CMD_RAMP, 12'd1000);
		send_item(CMD_RAMP, 12'd150);
		send_item(CMD_RAMP, 12'd150);
		send_item(CMD_RAMP, 12'd0);
		send_item(CMD_RAMP, 12'd0);
		send_item(CMD_FORWARD, 12'd4095);
		send_item(CMD_RAMP, 12'd4095);
		send_item(CMD_RAMP, 12'd0);
		send_item(CMD_FORWARD, 12'd4000);
		send_item(CMD_RAMP, 12'd4095);
		drain();

		// raised floor, full steps, left pin level inverted
		write_reg(REG_FLOOR_SPEED, 12'd500);
		write_reg(REG_RISE_STEP, 12'd4095);
		write_reg(REG_FALL_STEP, 12'd4095);
		write_reg(REG_LEFT_FWD, 12'hFFE);
		write_reg(REG_RIGHT_FWD, 12'h001);
		cfg_valid <= 1'b0;
		send_item(CMD_RAMP, 12'd100);
		send_item(CMD_RAMP, 12'd4095);
		send_item(CMD_RAMP, 12'd1);
		send_item(CMD_REVERSE, 12'd7);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_FLOOR_SPEED, (p == 0) ? 12'd0 : (p == 1) ? 12'hFFF : pick_step());
			write_reg(REG_RISE_STEP, (p == 0) ? 12'd0 : (p == 1) ? 12'hFFF : pick_step());
			write_reg(REG_FALL_STEP, (p == 0) ? 12'd0 : (p == 1) ? 12'hFFF : pick_step());
			write_reg(REG_LEFT_FWD, SPEED_W'($urandom_range(0, DUTY_MAX)));
			write_reg(REG_RIGHT_FWD, SPEED_W'($urandom_range(0, DUTY_MAX)));
			// unused index: must leave every register untouched
			write_reg(CFG_IDX_W'(REG_RIGHT_FWD + $urandom_range(1, 3)),
				SPEED_W'($urandom_range(0, DUTY_MAX)));
			cfg_valid <= 1'b0;
			no_idle = (p == 3);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 55) begin
					target = pick_speed();
					run = $urandom_range(1, 20);
					repeat (run) send_item(CMD_RAMP, target);
					sent += run;
				end else begin
					send_item(cmd_t'($urandom_range(0, 7)), pick_speed());
					sent++;
				end
			end
			drain();
		end
		no_idle = 1'b0;

		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: results missing, expected %0d more, actual 0",
				$time, sb.pending());
		end
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: differential_drive_speed_ramp.f
hdl/dds_pkg.sv
hdl/dds_ramp.sv
hdl/differential_drive_speed_ramp.sv
hdl/dds_checker.sv
verif/differential_drive_speed_ramp_tb.sv
